// ===== hw/rtl/slfp_pkg.sv =====
// shared types and constants for the sync/length frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package slfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 2 * ByteW + LenW;

  localparam logic [ByteW-1:0] SyncReset = 8'hAA;
  localparam logic [LenW-1:0] MaxLenReset = 16'hFFFF;

  localparam logic [CfgAddrW-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_SYNC = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_MAX_LEN = 2'd2;

  localparam logic [KindW-1:0] KIND_DATA = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KindW-1:0] KIND_DROP = 2'd2;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_ID = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_LEN_HI = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  typedef struct packed {
    logic enable;
    logic [ByteW-1:0] sync_value;
    logic [LenW-1:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] frame_id;
    logic [LenW-1:0] frame_len;
    logic [ByteW-1:0] payload_byte;
    logic last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slfp_in_stage.sv =====
// input register for received bytes
// depends on slfp_pkg
`default_nettype none

module slfp_in_stage (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  input wire logic [slfp_pkg::ByteW-1:0] s_tdata,
  input wire logic adv,
  output logic in_valid,
  output logic [slfp_pkg::ByteW-1:0] in_byte
);
  import slfp_pkg::*;

  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slfp_core.sv =====
// frame state machine: sync hunt, header capture, payload tagging
// depends on slfp_pkg
`default_nettype none

module slfp_core (
  input wire logic clk,
  input wire logic rst,
  input wire logic adv,
  input wire logic [slfp_pkg::ByteW-1:0] in_byte,
  input wire slfp_pkg::cfg_t cfg,
  output logic res_valid,
  output slfp_pkg::result_t res
);
  import slfp_pkg::*;

  phase_t phase, phase_next;
  logic [ByteW-1:0] held_id, held_id_next;
  logic [LenW-1:0] held_len, held_len_next;
  logic [LenW-1:0] bytes_left, bytes_left_next;
  logic [LenW-1:0] len_full;
  logic [LenW-1:0] left_dec;

  assign len_full = {in_byte, held_len[ByteW-1:0]};
  assign left_dec = bytes_left - LenW'(1);

  always_comb begin
    phase_next = phase;
    held_id_next = held_id;
    held_len_next = held_len;
    bytes_left_next = bytes_left;
    res_valid = 1'b0;
    res.kind = KIND_DATA;
    res.payload_byte = '0;
    res.last = 1'b1;
    if (cfg.enable) begin
      unique case (phase)
        PH_ID: begin
          held_id_next = in_byte;
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          held_len_next = {{(LenW-ByteW){1'b0}}, in_byte};
          phase_next = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          held_len_next = len_full;
          if (len_full == '0) begin
            phase_next = PH_HUNT;
            bytes_left_next = '0;
            res_valid = 1'b1;
            res.kind = KIND_EMPTY;
          end else if (len_full > cfg.max_payload_len) begin
            phase_next = PH_HUNT;
            bytes_left_next = '0;
            res_valid = 1'b1;
            res.kind = KIND_DROP;
          end else begin
            bytes_left_next = len_full;
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          bytes_left_next = left_dec;
          res_valid = 1'b1;
          res.kind = KIND_DATA;
          res.payload_byte = in_byte;
          res.last = (left_dec == '0);
          if (left_dec == '0) begin
            phase_next = PH_HUNT;
          end
        end
        default: begin
          phase_next = (in_byte == cfg.sync_value) ? PH_ID : PH_HUNT;
        end
      endcase
    end
    // header fields go out as they stand after this byte
    res.frame_id = held_id_next;
    res.frame_len = held_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      held_id <= '0;
      held_len <= '0;
      bytes_left <= '0;
    end else if (adv) begin
      phase <= phase_next;
      held_id <= held_id_next;
      held_len <= held_len_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slfp_out_reg.sv =====
// result register driving the master stream
// depends on slfp_pkg
`default_nettype none

module slfp_out_reg (
  input wire logic clk,
  input wire logic rst,
  input wire logic load,
  input wire slfp_pkg::result_t res,
  output logic m_tvalid,
  input wire logic m_tready,
  output logic [slfp_pkg::OutDataW-1:0] m_tdata,
  output logic [slfp_pkg::KindW-1:0] m_tuser,
  output logic m_tlast
);
  import slfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {res.payload_byte, res.frame_len, res.frame_id};
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sync_length_frame_parser.sv =====
// top level of the sync/length frame parser: config registers and stage wiring
// depends on slfp_pkg, slfp_in_stage, slfp_core, slfp_out_reg
//
// channel   dir  fields
// s_*       in   tdata[7:0] rx_byte
// m_*       out  tdata[7:0] frame_id, [23:8] frame_len, [31:24] payload_byte;
//                tuser[1:0] kind; tlast last
// cfg_*     in   cfg_addr 0 enable, 1 sync_value, 2 max_payload_len
//
// one byte per cycle unless the result register stalls; m_tvalid rises after the
// s_* accept edge (input register, then frame state machine into result register)
// a byte advances when the result register is empty or being taken
// rst clears config to defaults, the phase to hunting and both stages to empty
`default_nettype none

module sync_length_frame_parser (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  input wire logic [7:0] s_tdata,  // rx_byte
  output logic m_tvalid,
  input wire logic m_tready,
  output logic [31:0] m_tdata,  // frame_id, frame_len, payload_byte
  output logic [1:0] m_tuser,  // kind
  output logic m_tlast,
  input wire logic cfg_we,
  input wire logic [slfp_pkg::CfgAddrW-1:0] cfg_addr,
  input wire logic [slfp_pkg::CfgDataW-1:0] cfg_wdata
);
  import slfp_pkg::*;

  cfg_t cfg;
  logic in_valid;
  logic [ByteW-1:0] in_byte;
  logic adv;
  logic res_valid;
  result_t res;

  assign adv = in_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.sync_value <= SyncReset;
      cfg.max_payload_len <= MaxLenReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLE: cfg.enable <= cfg_wdata[0];
        CFG_SYNC: cfg.sync_value <= cfg_wdata[ByteW-1:0];
        CFG_MAX_LEN: cfg.max_payload_len <= cfg_wdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  slfp_in_stage u_in (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .adv(adv),
    .in_valid(in_valid),
    .in_byte(in_byte)
  );

  slfp_core u_core (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_byte(in_byte),
    .cfg(cfg),
    .res_valid(res_valid),
    .res(res)
  );

  slfp_out_reg u_out (
    .clk(clk),
    .rst(rst),
    .load(adv && res_valid),
    .res(res),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  a_ctrl_result_closes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_DATA |-> m_tlast && m_tdata[31:24] == '0)
    else $error("empty/drop word not marked last or carries data");

  a_empty_zero_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_EMPTY |-> m_tdata[23:8] == '0)
    else $error("empty-frame word with nonzero length");

  a_disabled_silent: assert property (@(posedge clk) disable iff (rst)
    adv && !cfg.enable && !m_tvalid |=> !m_tvalid)
    else $error("word produced while parser disabled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("stages not empty after reset");

endmodule

`default_nettype wire

// ===== verif/slfp_frame_checker.sv =====
// word checker for the sync/length frame parser: predicts every result word from
// the accepted input bytes and config writes, compares field by field
// depends on slfp_pkg
module slfp_frame_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [slfp_pkg::ByteW-1:0]    s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [31:0]                   m_tdata,
  input  logic [slfp_pkg::KindW-1:0]    m_tuser,
  input  logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [slfp_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [slfp_pkg::CfgDataW-1:0] cfg_wdata,
  output int                            errors,
  output int                            pending,
  output int                            words_seen
);
  import slfp_pkg::*;

  logic             parse_en;
  logic [ByteW-1:0] sync_byte;
  logic [LenW-1:0]  len_limit;

  phase_t           parse_phase;
  logic [ByteW-1:0] cur_id;
  logic [LenW-1:0]  cur_len;
  logic [LenW-1:0]  left_cnt;

  result_t expected_words[$];

  task automatic report(input string what, input logic [LenW-1:0] got,
                        input logic [LenW-1:0] want);
    errors++;
    if (errors <= 40)
      $display("slfp check: word %0d %s got %0h want %0h", words_seen, what, got, want);
  endtask

  task automatic apply_write(input logic [CfgAddrW-1:0] addr,
                             input logic [CfgDataW-1:0] data);
    case (addr)
      CFG_ENABLE:  parse_en = data[0];
      CFG_SYNC:    sync_byte = data[ByteW-1:0];
      CFG_MAX_LEN: len_limit = data[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic parse_byte(input logic [ByteW-1:0] b);
    result_t r;
    r = '0;
    if (!parse_en) return;
    case (parse_phase)
      PH_ID: begin
        cur_id = b;
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_len = {8'h00, b};
        parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_len = {b, cur_len[7:0]};
        r.frame_id = cur_id;
        r.frame_len = cur_len;
        r.last = 1'b1;
        if (cur_len == '0) begin
          parse_phase = PH_HUNT;
          left_cnt = '0;
          r.kind = KIND_EMPTY;
          expected_words.push_back(r);
        end else if (cur_len > len_limit) begin
          parse_phase = PH_HUNT;
          left_cnt = '0;
          r.kind = KIND_DROP;
          expected_words.push_back(r);
        end else begin
          left_cnt = cur_len;
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        left_cnt = left_cnt - 16'd1;
        r.kind = KIND_DATA;
        r.frame_id = cur_id;
        r.frame_len = cur_len;
        r.payload_byte = b;
        r.last = (left_cnt == '0);
        if (r.last) parse_phase = PH_HUNT;
        expected_words.push_back(r);
      end
      default: parse_phase = (b == sync_byte) ? PH_ID : PH_HUNT;
    endcase
  endtask

  task automatic check_word();
    result_t want;
    if (expected_words.size() == 0) begin
      report("word with nothing expected, kind", 16'(m_tuser), '0);
      return;
    end
    want = expected_words.pop_front();
    if (m_tuser !== want.kind) report("kind", 16'(m_tuser), 16'(want.kind));
    if (m_tdata[7:0] !== want.frame_id) report("frame_id", 16'(m_tdata[7:0]), 16'(want.frame_id));
    if (m_tdata[23:8] !== want.frame_len) report("frame_len", m_tdata[23:8], want.frame_len);
    if (m_tdata[31:24] !== want.payload_byte)
      report("payload_byte", 16'(m_tdata[31:24]), 16'(want.payload_byte));
    if (m_tlast !== want.last) report("last", 16'(m_tlast), 16'(want.last));
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_en = 1'b0;
      sync_byte = SyncReset;
      len_limit = MaxLenReset;
      parse_phase = PH_HUNT;
      cur_id = '0;
      cur_len = '0;
      left_cnt = '0;
      expected_words.delete();
      errors = 0;
      words_seen = 0;
    end else begin
      if (m_tvalid && m_tready) check_word();
      if (cfg_we) apply_write(cfg_addr, cfg_wdata);
      if (s_tvalid && s_tready) parse_byte(s_tdata);
    end
    pending = expected_words.size();
  end

endmodule

// ===== verif/sync_length_frame_parser_tb.sv =====
// testbench top for the sync/length frame parser: directed frames, then phases of
// random frames, noise and broken headers under several register settings
// depends on slfp_pkg, slfp_frame_checker and the sync_length_frame_parser rtl
module sync_length_frame_parser_tb;
  import slfp_pkg::*;

  localparam int ItemTarget = 1200;
  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;
  localparam logic [CfgAddrW-1:0] CFG_SPARE = 2'd3;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // rx_byte
  logic                m_tvalid;
  logic                m_tready;
  logic [31:0]         m_tdata;   // frame_id, frame_len, payload_byte
  logic [1:0]          m_tuser;   // kind
  logic                m_tlast;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  int errors;
  int pending;
  int words_seen;

  int  cycles = 0;
  int  items = 0;
  int  headers = 0;
  int  settings = 0;
  bit  calm = 1'b0;
  bit  want_hold = 1'b0;

  logic             en_now = 1'b0;
  logic [ByteW-1:0] sync_now = SyncReset;
  logic [LenW-1:0]  limit_now = MaxLenReset;

  sync_length_frame_parser u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  slfp_frame_checker u_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .errors(errors),
    .pending(pending),
    .words_seen(words_seen)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sync_length_frame_parser_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    repeat (8) @(negedge clk);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (en_now) items++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [7:0] id, input logic [15:0] len);
    headers++;
    send_byte(sync_now);
    send_byte(id);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  // wait until every predicted word has come out, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_ENABLE:  en_now = data[0];
      CFG_SYNC:    sync_now = data[ByteW-1:0];
      CFG_MAX_LEN: limit_now = data;
      default: ;
    endcase
    settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_frame();
    int pick;
    int n;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      n = $urandom_range(0, 19);
      if (n == 0) len = '0;
      else if (n == 1) len = 16'($urandom_range(13, 300));
      else len = 16'($urandom_range(1, 12));
      send_header(8'($urandom), len);
      if (len != 0 && len <= limit_now) repeat (len) send_byte(8'($urandom));
    end else if (pick < 78) begin
      if (limit_now == 16'hFFFF) len = '0;
      else len = 16'($urandom_range(int'(limit_now) + 1, 65535));
      send_header(8'($urandom), len);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else begin
      // header cut short, the next frame's bytes land in it
      send_byte(sync_now);
      repeat ($urandom_range(1, 2)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int phase_no;
    int stop_at;
    bit held;
    bit paused;
    phase_no = 0;
    held = 1'b0;
    paused = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled after reset: ignored
    send_byte(SyncReset);
    send_byte(8'h12);
    settle();
    cfg_write(CFG_ENABLE, 16'hFFFF);
    cfg_write(CFG_SPARE, 16'hFFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(8'h00, 16'h0000);
    send_header(8'hFF, 16'h0001);
    send_byte(8'hFF);
    // sync value as payload
    send_header(8'h5A, 16'h0002);
    send_byte(sync_now);
    send_byte(8'h00);
    settle();
    cfg_write(CFG_MAX_LEN, 16'h0003);
    send_header(8'h01, 16'h0004);
    send_header(8'h02, 16'h0003);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    settle();
    cfg_write(CFG_MAX_LEN, 16'hFFFE);
    send_header(8'hC3, 16'hFFFF);
    settle();
    cfg_write(CFG_MAX_LEN, 16'h0000);
    send_header(8'h3C, 16'h0001);
    // disable in the middle of a payload
    settle();
    cfg_write(CFG_MAX_LEN, 16'hFFFF);
    send_header(8'h07, 16'h0003);
    send_byte(8'h11);
    settle();
    cfg_write(CFG_ENABLE, 16'hFFFE);
    send_byte(8'h22);
    send_byte(8'h33);
    settle();
    cfg_write(CFG_ENABLE, 16'h0001);
    send_byte(8'h44);
    send_byte(8'h55);
    settle();
    cfg_write(CFG_SYNC, 16'hFF00);
    send_byte(8'hAA);
    send_header(8'h99, 16'h0001);
    send_byte(8'h00);

    while (items < ItemTarget) begin
      settle();
      cfg_write(CFG_ENABLE, {15'($urandom), 1'b1});
      case (phase_no % 6)
        0: begin
          cfg_write(CFG_SYNC, 16'(SyncReset));
          cfg_write(CFG_MAX_LEN, 16'hFFFF);
        end
        1: begin
          cfg_write(CFG_SYNC, 16'h0000);
          cfg_write(CFG_MAX_LEN, 16'h0000);
        end
        2: begin
          cfg_write(CFG_SYNC, 16'h00FF);
          cfg_write(CFG_MAX_LEN, 16'h0008);
        end
        3: begin
          cfg_write(CFG_SYNC, 16'($urandom));
          cfg_write(CFG_MAX_LEN, 16'($urandom_range(0, 300)));
        end
        4: begin
          cfg_write(CFG_SYNC, 16'($urandom));
          cfg_write(CFG_MAX_LEN, 16'hFFFF);
        end
        default: begin
          cfg_write(CFG_SYNC, 16'($urandom));
          cfg_write(CFG_MAX_LEN, 16'($urandom));
        end
      endcase
      stop_at = items + 150;
      while (items < stop_at && items < ItemTarget) begin
        if (items >= ItemTarget - 150) calm = 1'b1;
        send_random_frame();
        if (phase_no == 2 && !held) begin
          held = 1'b1;
          want_hold = 1'b1;
        end
        if (phase_no == 3 && !paused && items > stop_at - 75) begin
          paused = 1'b1;
          settle();
        end
      end
      phase_no++;
    end

    settle();
    repeat (8) @(negedge clk);
    $display("sync_length_frame_parser_tb: %0d bytes parsed, %0d headers, %0d words checked",
             items, headers, words_seen);
    $display("sync_length_frame_parser_tb: %0d register writes over %0d random phases",
             settings, phase_no);
    if (errors == 0) begin
      $display("sync_length_frame_parser_tb: done, clean");
    end else begin
      $display("sync_length_frame_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
